>>> src/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types and codes for the collider pose transform pipeline
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int COORD_W = 32;
    localparam int QUAT_W  = 16;
    localparam int IDX_W   = 8;
    localparam int ROT_W   = 40;

    typedef logic [2:0] t_kind;
    typedef logic [1:0] t_role;

    localparam t_kind KIND_BOX     = 3'd0;
    localparam t_kind KIND_SPHERE  = 3'd1;
    localparam t_kind KIND_CAPSULE = 3'd2;
    localparam t_kind KIND_CONVEX  = 3'd3;

    localparam t_role ROLE_CENTER = 2'd0;
    localparam t_role ROLE_TOP    = 2'd1;
    localparam t_role ROLE_BOTTOM = 2'd2;
    localparam t_role ROLE_VERTEX = 2'd3;

    typedef struct packed {
        t_kind                     shape_kind;
        logic signed [QUAT_W-1:0]  quat_w;
        logic signed [QUAT_W-1:0]  quat_x;
        logic signed [QUAT_W-1:0]  quat_y;
        logic signed [QUAT_W-1:0]  quat_z;
        logic signed [COORD_W-1:0] trans_x;
        logic signed [COORD_W-1:0] trans_y;
        logic signed [COORD_W-1:0] trans_z;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [IDX_W-1:0]          vertex_index;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        t_role                     point_role;
        logic [IDX_W-1:0]          echo_index;
        logic                      last_of_run;
    } t_out_beat;

    // one point on its way through the pipeline
    typedef struct packed {
        logic signed [QUAT_W-1:0]  quat_w;
        logic signed [QUAT_W-1:0]  quat_x;
        logic signed [QUAT_W-1:0]  quat_y;
        logic signed [QUAT_W-1:0]  quat_z;
        logic signed [COORD_W-1:0] trans_x;
        logic signed [COORD_W-1:0] trans_y;
        logic signed [COORD_W-1:0] trans_z;
        logic signed [COORD_W-1:0] vec_x;
        logic signed [COORD_W-1:0] vec_y;
        logic signed [COORD_W-1:0] vec_z;
        t_role                     role;
        logic [IDX_W-1:0]          idx;
        logic                      last;
    } t_work;

    typedef struct packed {
        logic signed [ROT_W-1:0] rot_x;
        logic signed [ROT_W-1:0] rot_y;
        logic signed [ROT_W-1:0] rot_z;
    } t_rot;

endpackage

>>> src/cpt_front.sv
// ----------------------------------------------------------------------------
// cpt_front
// Input stage: decodes the shape kind, drops unknown kinds and vertex indexes
// at or above MAX_VERTICES, splits a capsule into its top and bottom end points
// ----------------------------------------------------------------------------
module cpt_front #(
    parameter int MAX_VERTICES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  cpt_pkg::t_in_beat i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output cpt_pkg::t_work   o_data
);
    import cpt_pkg::*;

    localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W+1)'(MAX_VERTICES);

    logic  r_valid, n_valid;
    logic  r_pend, n_pend;
    t_work r_work, n_work;
    logic  w_en;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en && !r_pend;
    assign o_valid = r_valid;
    assign o_data  = r_work;

    always_comb begin
        n_work  = r_work;
        n_valid = r_valid;
        n_pend  = r_pend;
        if (w_en) begin
            n_valid = 1'b0;
            if (r_pend) begin
                // bottom end reuses the held item with the half height negated
                n_work.vec_y = -r_work.vec_y;
                n_work.role  = ROLE_BOTTOM;
                n_work.last  = 1'b1;
                n_valid      = 1'b1;
                n_pend       = 1'b0;
            end else if (i_valid) begin
                n_work.quat_w  = i_data.quat_w;
                n_work.quat_x  = i_data.quat_x;
                n_work.quat_y  = i_data.quat_y;
                n_work.quat_z  = i_data.quat_z;
                n_work.trans_x = i_data.trans_x;
                n_work.trans_y = i_data.trans_y;
                n_work.trans_z = i_data.trans_z;
                n_work.vec_x   = '0;
                n_work.vec_y   = '0;
                n_work.vec_z   = '0;
                n_work.role    = ROLE_CENTER;
                n_work.idx     = '0;
                n_work.last    = 1'b1;
                case (i_data.shape_kind)
                    KIND_BOX, KIND_SPHERE: begin
                        n_valid = 1'b1;
                    end
                    KIND_CAPSULE: begin
                        n_work.vec_y = i_data.point_y >>> 1;
                        n_work.role  = ROLE_TOP;
                        n_work.last  = 1'b0;
                        n_valid      = 1'b1;
                        n_pend       = 1'b1;
                    end
                    KIND_CONVEX: begin
                        n_work.vec_x = i_data.point_x;
                        n_work.vec_y = i_data.point_y;
                        n_work.vec_z = i_data.point_z;
                        n_work.role  = ROLE_VERTEX;
                        n_work.idx   = i_data.vertex_index;
                        n_valid      = ({1'b0, i_data.vertex_index} < IDX_LIMIT);
                    end
                    default: begin
                        n_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
    end

    a_pend_holds_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_valid && r_work.role == ROLE_TOP))
        else $error("pending bottom end without a held top end");

    a_unknown_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_data.shape_kind[2]) |=> !r_valid)
        else $error("unknown shape kind produced a beat");

endmodule

>>> src/cpt_rotate.sv
// ----------------------------------------------------------------------------
// cpt_rotate
// Four stage quaternion rotation: t = 2(q x v) products, t rounding,
// q x t and w*t products, sum and rounding
// ----------------------------------------------------------------------------
module cpt_rotate (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cpt_pkg::t_work i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output cpt_pkg::t_work o_data,
    output cpt_pkg::t_rot  o_rot
);
    import cpt_pkg::*;

    localparam int P1_W = QUAT_W + COORD_W;   // 48
    localparam int T_W  = P1_W + 2 - 14;      // 36
    localparam int P2_W = QUAT_W + T_W;       // 52
    localparam int S_W  = P2_W + 2;           // 54

    function automatic logic signed [P1_W-1:0] mul_qv(
        input logic signed [QUAT_W-1:0]  a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [P1_W-1:0] ea;
        logic signed [P1_W-1:0] eb;
        ea = a;
        eb = b;
        return ea * eb;
    endfunction

    function automatic logic signed [P2_W-1:0] mul_qt(
        input logic signed [QUAT_W-1:0] a,
        input logic signed [T_W-1:0]    b
    );
        logic signed [P2_W-1:0] ea;
        logic signed [P2_W-1:0] eb;
        ea = a;
        eb = b;
        return ea * eb;
    endfunction

    // round(2*(a-b) / 2^14), half up
    function automatic logic signed [T_W-1:0] rnd_t(
        input logic signed [P1_W-1:0] a,
        input logic signed [P1_W-1:0] b
    );
        logic signed [P1_W+1:0] ea;
        logic signed [P1_W+1:0] eb;
        logic signed [P1_W+1:0] d;
        ea = a;
        eb = b;
        d  = (ea - eb) <<< 1;
        d  = d + (P1_W+2)'(15'sh2000);
        return d[P1_W+1:14];
    endfunction

    // round((a+b-c) / 2^14), half up
    function automatic logic signed [ROT_W-1:0] rnd_s(
        input logic signed [P2_W-1:0] a,
        input logic signed [P2_W-1:0] b,
        input logic signed [P2_W-1:0] c
    );
        logic signed [S_W-1:0] ea;
        logic signed [S_W-1:0] eb;
        logic signed [S_W-1:0] ec;
        logic signed [S_W-1:0] s;
        ea = a;
        eb = b;
        ec = c;
        s  = ea + eb - ec + S_W'(15'sh2000);
        return s[S_W-1:14];
    endfunction

    logic                   r1_v, r2_v, r3_v, r4_v;
    t_work                  r1_w, r2_w, r3_w, r4_w;
    logic signed [P1_W-1:0] r1_p [6];
    logic signed [T_W-1:0]  r2_t [3];
    logic signed [P2_W-1:0] r3_p [9];
    t_rot                   r4_rot;
    logic                   w_en1, w_en2, w_en3, w_en4;

    assign w_en4   = !r4_v || i_ready;
    assign w_en3   = !r3_v || w_en4;
    assign w_en2   = !r2_v || w_en3;
    assign w_en1   = !r1_v || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r4_v;
    assign o_data  = r4_w;
    assign o_rot   = r4_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (w_en1) r1_v <= i_valid;
            if (w_en2) r2_v <= r1_v;
            if (w_en3) r3_v <= r2_v;
            if (w_en4) r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_w    <= i_data;
            r1_p[0] <= mul_qv(i_data.quat_y, i_data.vec_z);
            r1_p[1] <= mul_qv(i_data.quat_z, i_data.vec_y);
            r1_p[2] <= mul_qv(i_data.quat_z, i_data.vec_x);
            r1_p[3] <= mul_qv(i_data.quat_x, i_data.vec_z);
            r1_p[4] <= mul_qv(i_data.quat_x, i_data.vec_y);
            r1_p[5] <= mul_qv(i_data.quat_y, i_data.vec_x);
        end
        if (w_en2) begin
            r2_w    <= r1_w;
            r2_t[0] <= rnd_t(r1_p[0], r1_p[1]);
            r2_t[1] <= rnd_t(r1_p[2], r1_p[3]);
            r2_t[2] <= rnd_t(r1_p[4], r1_p[5]);
        end
        if (w_en3) begin
            r3_w    <= r2_w;
            r3_p[0] <= mul_qt(r2_w.quat_w, r2_t[0]);
            r3_p[1] <= mul_qt(r2_w.quat_y, r2_t[2]);
            r3_p[2] <= mul_qt(r2_w.quat_z, r2_t[1]);
            r3_p[3] <= mul_qt(r2_w.quat_w, r2_t[1]);
            r3_p[4] <= mul_qt(r2_w.quat_z, r2_t[0]);
            r3_p[5] <= mul_qt(r2_w.quat_x, r2_t[2]);
            r3_p[6] <= mul_qt(r2_w.quat_w, r2_t[2]);
            r3_p[7] <= mul_qt(r2_w.quat_x, r2_t[1]);
            r3_p[8] <= mul_qt(r2_w.quat_y, r2_t[0]);
        end
        if (w_en4) begin
            r4_w         <= r3_w;
            r4_rot.rot_x <= rnd_s(r3_p[0], r3_p[1], r3_p[2]);
            r4_rot.rot_y <= rnd_s(r3_p[3], r3_p[4], r3_p[5]);
            r4_rot.rot_z <= rnd_s(r3_p[6], r3_p[7], r3_p[8]);
        end
    end

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_v && !i_ready) |=> (r4_v && $stable(r4_rot)))
        else $error("stalled rotation result changed");

endmodule

>>> src/collider_pose_transform.sv
// ----------------------------------------------------------------------------
// collider_pose_transform
// Places collider points in world space: rotation by a Q2.14 quaternion and
// translation, with 32-bit saturation
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready/i_data carries one shape beat; output channel
// o_valid/i_ready/o_data carries one world point per beat.
// Box and sphere give one center point, a convex vertex gives one rotated
// point with its index echoed, a capsule gives its top then its bottom end.
// Unknown kinds and vertex indexes at or above MAX_VERTICES give nothing.
// A result passes through the front register, the four rotation stages and
// the saturating output register. Throughput: one input beat per cycle while
// the output is not held off; a capsule holds off the next input beat while
// its bottom end enters.
// Every stage has its own valid bit and loads whenever it is empty or the
// next stage moves, so bubbles close up; when the receiver holds i_ready
// low the pipeline fills and o_ready drops, nothing is lost or repeated.
// Reset clears all valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module collider_pose_transform #(
    parameter int MAX_VERTICES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  cpt_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output cpt_pkg::t_out_beat o_data
);
    import cpt_pkg::*;

    localparam int SUM_W = ROT_W + 2;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(33'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-33'sd2147483648);

    function automatic logic signed [COORD_W-1:0] place(
        input logic signed [COORD_W-1:0] v,
        input logic signed [ROT_W-1:0]   r,
        input logic signed [COORD_W-1:0] t
    );
        logic signed [SUM_W-1:0] ev;
        logic signed [SUM_W-1:0] er;
        logic signed [SUM_W-1:0] et;
        logic signed [SUM_W-1:0] s;
        ev = v;
        er = r;
        et = t;
        s  = ev + er + et;
        if (s > SAT_HI) begin
            s = SAT_HI;
        end else if (s < SAT_LO) begin
            s = SAT_LO;
        end
        return s[COORD_W-1:0];
    endfunction

    logic      w_f_valid, w_f_ready;
    t_work     w_f_data;
    logic      w_r_valid, w_r_ready;
    t_work     w_r_data;
    t_rot      w_r_rot;
    logic      r_ovalid;
    t_out_beat r_out, n_out;

    cpt_front #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_data  (w_f_data)
    );

    cpt_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_data),
        .o_valid (w_r_valid),
        .i_ready (w_r_ready),
        .o_data  (w_r_data),
        .o_rot   (w_r_rot)
    );

    assign w_r_ready = !r_ovalid || i_ready;

    always_comb begin
        n_out.out_x       = place(w_r_data.vec_x, w_r_rot.rot_x, w_r_data.trans_x);
        n_out.out_y       = place(w_r_data.vec_y, w_r_rot.rot_y, w_r_data.trans_y);
        n_out.out_z       = place(w_r_data.vec_z, w_r_rot.rot_z, w_r_data.trans_z);
        n_out.point_role  = w_r_data.role;
        n_out.echo_index  = w_r_data.idx;
        n_out.last_of_run = w_r_data.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_r_ready) begin
            r_ovalid <= w_r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_r_ready) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    a_top_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.point_role == ROLE_TOP) |-> !o_data.last_of_run)
        else $error("capsule top end marked last");

    a_bottom_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.point_role == ROLE_BOTTOM) |-> o_data.last_of_run)
        else $error("capsule bottom end not marked last");

    a_center_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.point_role == ROLE_CENTER)
            |-> (o_data.last_of_run && o_data.echo_index == '0))
        else $error("center point with index or without last");

endmodule

>>> tb/tb_collider_pose_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_collider_pose_transform
// Self-checking bench for the collider pose transform pipeline
// ----------------------------------------------------------------------------
// Shape beats come from a queue filled at start: a short directed set (extreme
// translations and points, every shape kind, odd and negative capsule heights,
// saturation both ways, unnormalized and zero quaternions, ignored kinds),
// then random beats. Each accepted beat is run through a fixed-point model of
// the quaternion rotation and translation, and every output beat is compared
// field by field against the oldest predicted world point. Both sides idle in
// random bursts, and once the receiver holds off long enough to back up the
// whole pipeline.
// ----------------------------------------------------------------------------
module tb_collider_pose_transform;
    import cpt_pkg::*;

    localparam int MAX_VERTS    = 256;
    localparam int RAND_BEATS   = 500;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_TRIGGER = 120;
    localparam int TAIL_BEATS   = 40;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;

    logic       i_clk;
    logic       rst_n   = 1'b0;
    logic       in_vld  = 1'b0;
    t_in_beat   in_data = '0;
    logic       out_rdy = 1'b0;
    logic       o_ready;
    logic       o_valid;
    t_out_beat  o_data;

    t_in_beat   shape_beats_q[$];
    t_out_beat  world_pts_q[$];

    logic       in_taken  = 1'b0;
    logic       idle_on   = 1'b1;
    logic       long_done = 1'b0;
    int         gap_left  = 0;
    int         stall_left = 0;
    int         hold_left = 0;
    int         beats_in  = 0;
    int         errors    = 0;
    int         cycle_cnt = 0;

    collider_pose_transform #(
        .MAX_VERTICES(MAX_VERTS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (rst_n),
        .i_valid (in_vld),
        .o_ready (o_ready),
        .i_data  (in_data),
        .o_valid (o_valid),
        .i_ready (out_rdy),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- world point model ----------------

    function automatic longint round_q14(longint x);
        return (x + 64'sd8192) >>> 14;
    endfunction

    function automatic logic signed [31:0] sat_word(longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic void spin(input longint qw, qx, qy, qz, vx, vy, vz,
                                 output longint rx, ry, rz);
        longint tx, ty, tz;
        tx = round_q14(2 * (qy * vz - qz * vy));
        ty = round_q14(2 * (qz * vx - qx * vz));
        tz = round_q14(2 * (qx * vy - qy * vx));
        rx = vx + round_q14(qw * tx + (qy * tz - qz * ty));
        ry = vy + round_q14(qw * ty + (qz * tx - qx * tz));
        rz = vz + round_q14(qw * tz + (qx * ty - qy * tx));
    endfunction

    function automatic void push_point(longint rx, ry, rz, t_in_beat b, t_role role,
                                       logic [IDX_W-1:0] idx, logic last);
        t_out_beat p;
        p.out_x       = sat_word(rx + longint'(b.trans_x));
        p.out_y       = sat_word(ry + longint'(b.trans_y));
        p.out_z       = sat_word(rz + longint'(b.trans_z));
        p.point_role  = role;
        p.echo_index  = idx;
        p.last_of_run = last;
        world_pts_q.push_back(p);
    endfunction

    function automatic void place_collider(t_in_beat b);
        longint qw, qx, qy, qz, h, rx, ry, rz;
        qw = longint'(b.quat_w);
        qx = longint'(b.quat_x);
        qy = longint'(b.quat_y);
        qz = longint'(b.quat_z);
        case (b.shape_kind)
            KIND_BOX, KIND_SPHERE: begin
                push_point(0, 0, 0, b, ROLE_CENTER, '0, 1'b1);
            end
            KIND_CAPSULE: begin
                h = longint'(b.point_y) >>> 1;
                spin(qw, qx, qy, qz, 0, h, 0, rx, ry, rz);
                push_point(rx, ry, rz, b, ROLE_TOP, '0, 1'b0);
                spin(qw, qx, qy, qz, 0, -h, 0, rx, ry, rz);
                push_point(rx, ry, rz, b, ROLE_BOTTOM, '0, 1'b1);
            end
            KIND_CONVEX: begin
                if (int'(b.vertex_index) < MAX_VERTS) begin
                    spin(qw, qx, qy, qz, longint'(b.point_x), longint'(b.point_y),
                         longint'(b.point_z), rx, ry, rz);
                    push_point(rx, ry, rz, b, ROLE_VERTEX, b.vertex_index, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic t_in_beat shape_beat(t_kind kind,
            logic signed [15:0] qw, qx, qy, qz,
            logic signed [31:0] tx, ty, tz, px, py, pz, logic [7:0] idx);
        t_in_beat b;
        b.shape_kind   = kind;
        b.quat_w       = qw;
        b.quat_x       = qx;
        b.quat_y       = qy;
        b.quat_z       = qz;
        b.trans_x      = tx;
        b.trans_y      = ty;
        b.trans_z      = tz;
        b.point_x      = px;
        b.point_y      = py;
        b.point_z      = pz;
        b.vertex_index = idx;
        return b;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 32'h001FFFFF)) - 32'sh00100000;
            2: begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh7FFFFFFF;
                    1: v = 32'sh80000000;
                    2: v = 32'sd0;
                    3: v = -32'sd1;
                    default: v = 32'sd65536;
                endcase
            end
            default: v = $signed($urandom_range(0, 32'h1FFFFFFF)) - 32'sh10000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] rand_quat();
        logic signed [15:0] v;
        if ($urandom_range(0, 2) == 0) begin
            v = 16'($urandom);
        end else begin
            v = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        end
        return v;
    endfunction

    function automatic t_in_beat rand_beat(t_kind kind);
        return shape_beat(kind, rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                          rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord(), 8'($urandom));
    endfunction

    // ---------------- sender ----------------

    always @(negedge i_clk) begin
        if (!rst_n) begin
            in_vld   <= 1'b0;
            gap_left <= 0;
        end else if (!in_vld || in_taken) begin
            if (gap_left > 0) begin
                in_vld   <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                in_vld   <= 1'b0;
                gap_left <= $urandom_range(0, 17);
            end else if (shape_beats_q.size() > 0) begin
                in_data <= shape_beats_q.pop_front();
                in_vld  <= 1'b1;
            end else begin
                in_vld <= 1'b0;
            end
        end
    end

    // ---------------- receiver ----------------

    always @(negedge i_clk) begin
        if (!rst_n) begin
            out_rdy <= 1'b0;
        end else if (hold_left > 0) begin
            out_rdy   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_done && beats_in >= HOLD_TRIGGER) begin
            out_rdy   <= 1'b0;
            hold_left <= LONG_HOLD - 1;
            long_done <= 1'b1;
        end else if (stall_left > 0) begin
            out_rdy    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_rdy    <= 1'b0;
            stall_left <= $urandom_range(0, 17);
        end else begin
            out_rdy <= 1'b1;
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        t_out_beat want;
        if (rst_n) begin
            in_taken <= in_vld && o_ready;
            if (in_vld && o_ready) begin
                place_collider(in_data);
                beats_in <= beats_in + 1;
            end
            if (o_valid && out_rdy) begin
                if (world_pts_q.size() == 0) begin
                    errors <= errors + 1;
                    if (errors < REPORT_MAX) begin
                        $display("unexpected beat: x=%0d y=%0d z=%0d role=%0d idx=%0d last=%0b",
                                 o_data.out_x, o_data.out_y, o_data.out_z,
                                 o_data.point_role, o_data.echo_index, o_data.last_of_run);
                    end
                end else begin
                    want = world_pts_q.pop_front();
                    if (o_data.out_x !== want.out_x || o_data.out_y !== want.out_y ||
                        o_data.out_z !== want.out_z ||
                        o_data.point_role !== want.point_role ||
                        o_data.echo_index !== want.echo_index ||
                        o_data.last_of_run !== want.last_of_run) begin
                        errors <= errors + 1;
                        if (errors < REPORT_MAX) begin
                            $display("mismatch: exp x=%0d y=%0d z=%0d role=%0d idx=%0d last=%0b",
                                     want.out_x, want.out_y, want.out_z,
                                     want.point_role, want.echo_index, want.last_of_run);
                            $display("          got x=%0d y=%0d z=%0d role=%0d idx=%0d last=%0b",
                                     o_data.out_x, o_data.out_y, o_data.out_z,
                                     o_data.point_role, o_data.echo_index,
                                     o_data.last_of_run);
                        end
                    end
                end
            end
        end
    end

    // ---------------- watchdog ----------------

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ---------------- sequence ----------------

    initial begin
        int useful;
        t_kind k;

        // directed set
        shape_beats_q.push_back(shape_beat(KIND_BOX, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
            32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sd5, 32'sd6, 32'sd7, 8'd9));
        shape_beats_q.push_back(shape_beat(KIND_SPHERE, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
            32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
            32'sh7FFFFFFF, 8'd255));
        shape_beats_q.push_back(shape_beat(KIND_CAPSULE, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
            32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sh7FFFFFFF, 32'sd0, 8'd0));
        shape_beats_q.push_back(shape_beat(KIND_CAPSULE, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
            32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sd0, 32'sh80000000, 32'sd0, 8'd0));
        shape_beats_q.push_back(shape_beat(KIND_CAPSULE, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
            32'sd100, 32'sd0, 32'sd0, 32'sd0, -32'sd3, 32'sd0, 8'd0));
        shape_beats_q.push_back(shape_beat(KIND_CAPSULE, 16'sd11585, 16'sd0, 16'sd0, 16'sd0,
            32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 8'd0));
        shape_beats_q.push_back(shape_beat(KIND_CAPSULE, 16'sd11585, 16'sd0, 16'sd0, 16'sd11585,
            32'sd65536, -32'sd65536, 32'sd0, 32'sh7FFFFFFF, 32'sd131073, 32'sh80000000, 8'd77));
        shape_beats_q.push_back(shape_beat(KIND_CAPSULE, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000,
            32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sh7FFFFFFF, 32'sd0, 8'd0));
        shape_beats_q.push_back(shape_beat(KIND_CONVEX, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
            32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
            32'sh7FFFFFFF, 8'd255));
        shape_beats_q.push_back(shape_beat(KIND_CONVEX, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
            32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
            32'sh80000000, 8'd0));
        shape_beats_q.push_back(shape_beat(KIND_CONVEX, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
            32'sd0, 32'sd0, 32'sd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 8'd128));
        shape_beats_q.push_back(shape_beat(KIND_CONVEX, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
            32'sd0, 32'sd0, 32'sd0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 8'd1));
        shape_beats_q.push_back(shape_beat(KIND_CONVEX, 16'sd0, 16'sh7FFF, 16'sh8000, 16'sd12345,
            32'sd1, -32'sd1, 32'sd0, 32'sd123456, -32'sd654321, 32'sd999999, 8'd42));
        shape_beats_q.push_back(shape_beat(KIND_CONVEX, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
            32'sd0, 32'sd0, 32'sd0, 32'sh7FFFFFFF, 32'sh80000000, -32'sd1, 8'd200));
        shape_beats_q.push_back(shape_beat(KIND_CONVEX, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192,
            32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd65536, 32'sd65536, 8'd3));
        shape_beats_q.push_back(shape_beat(KIND_CAPSULE, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
            32'sd0, 32'sd0, 32'sd0, 32'sh7FFFFFFF, 32'sd1, 32'sh80000000, 8'd255));
        shape_beats_q.push_back(rand_beat(3'd4));
        shape_beats_q.push_back(rand_beat(3'd5));
        shape_beats_q.push_back(rand_beat(3'd6));
        shape_beats_q.push_back(rand_beat(3'd7));

        // random part, ignored kinds not counted
        useful = 0;
        while (useful < RAND_BEATS) begin
            if ($urandom_range(0, 9) == 0) begin
                k = 3'($urandom_range(4, 7));
            end else begin
                k = 3'($urandom_range(0, 3));
                useful++;
            end
            shape_beats_q.push_back(rand_beat(k));
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // no idling for the tail of the run
        while (shape_beats_q.size() > TAIL_BEATS) @(posedge i_clk);
        idle_on = 1'b0;

        while (shape_beats_q.size() > 0 || in_vld) @(posedge i_clk);
        while (world_pts_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && world_pts_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
